/* rtl/mdsd_pkg.sv */
// Shared constants, codes and types of the multiplexed display shift driver.
`timescale 1ns / 1ps
`default_nettype none

package mdsd_pkg;

    localparam int MAX_SENSORS = 8;
    localparam int DIGITS      = 5;
    localparam int SHIFT_BITS  = 16;

    localparam int CODE_W     = 16;
    localparam int CODE_DEPTH = MAX_SENSORS * DIGITS;
    localparam int ADDR_W     = $clog2(CODE_DEPTH + DIGITS);
    localparam int RAM_AW     = $clog2(CODE_DEPTH);
    localparam int DIGIT_W    = $clog2(DIGITS);
    localparam int BASE_W     = $clog2(MAX_SENSORS);
    localparam int COUNT_W    = $clog2(MAX_SENSORS + 3);
    localparam int DATA_STEPS = 2 * SHIFT_BITS;
    localparam int STEP_W     = $clog2(DATA_STEPS + 5);

    localparam logic [STEP_W-1:0] STEP_DATA_END = STEP_W'(DATA_STEPS);
    localparam logic [STEP_W-1:0] STEP_LATCH_ON = STEP_W'(DATA_STEPS + 1);
    localparam logic [STEP_W-1:0] STEP_LATCH_OFF = STEP_W'(DATA_STEPS + 2);
    localparam logic [STEP_W-1:0] STEP_ENABLE = STEP_W'(DATA_STEPS + 3);

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_DIGIT = 2'd1,
        MODE_BIT   = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_SENSOR_COUNT   = 3'd0,
        CFG_PAIR_HOLD_TOP  = 3'd1,
        CFG_SECOND_TOP     = 3'd2,
        CFG_BLINK_PERIOD   = 3'd3,
        CFG_BLINK_DURATION = 3'd4
    } cfg_index_t;

    typedef struct packed {
        mode_t              mode;
        logic [DIGIT_W-1:0] digit;
        logic               pair_pulse;
        logic               second_pulse;
        logic               led;
        logic               hi_ok;
        logic               lo_ok;
    } stage_t;

    typedef struct packed {
        logic              shift_clock;
        logic              data_high;
        logic              data_low;
        logic              latch_enable;
        logic              output_disable;
        logic [DIGITS-1:0] anode_select;
        logic              indicator_led;
        logic              pair_pulse;
        logic              second_pulse;
        logic              busy_res;
    } result_t;

endpackage

`default_nettype wire

/* rtl/mdsd_if.sv */
// Request, result and register-write channel interfaces of the display driver.
`timescale 1ns / 1ps
`default_nettype none

interface mdsd_item_if import mdsd_pkg::*;;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [2:0]  sensor_index;
    logic [2:0]  digit_index;
    logic [15:0] code_value;
    logic        button_indicator;

    modport source(output valid, mode, sensor_index, digit_index, code_value,
                   button_indicator, input ready);
    modport sink(input valid, mode, sensor_index, digit_index, code_value,
                 button_indicator, output ready);
endinterface

interface mdsd_result_if import mdsd_pkg::*;;
    logic              valid;
    logic              ready;
    logic              shift_clock;
    logic              data_high;
    logic              data_low;
    logic              latch_enable;
    logic              output_disable;
    logic [DIGITS-1:0] anode_select;
    logic              indicator_led;
    logic              pair_pulse;
    logic              second_pulse;
    logic              busy_res;

    modport source(output valid, shift_clock, data_high, data_low, latch_enable,
                   output_disable, anode_select, indicator_led, pair_pulse,
                   second_pulse, busy_res, input ready);
    modport sink(input valid, shift_clock, data_high, data_low, latch_enable,
                 output_disable, anode_select, indicator_led, pair_pulse,
                 second_pulse, busy_res, output ready);
endinterface

interface mdsd_cfg_if import mdsd_pkg::*;;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/multiplexed_display_shift_driver.sv */
// Top level of the multiplexed display shift driver.
// An accepted request passes the code memory read and stage register first, then the
// pin update into the output register, which holds a stalled result.
// One request is accepted every cycle unless a result stall fills the stage register.
// Reset is asynchronous and active low; code memory entries read as zero until written,
// through per-entry valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_display_shift_driver import mdsd_pkg::*; (
    input wire logic      clk,
    input wire logic      rst_n,
    mdsd_item_if.sink     item,
    mdsd_result_if.source result,
    mdsd_cfg_if.sink      cfg
);

    logic [3:0]  sensor_count_reg;
    logic [15:0] pair_hold_top_reg;
    logic [15:0] second_top_reg;
    logic [7:0]  blink_period_reg;
    logic [7:0]  blink_duration_reg;

    logic [DIGIT_W-1:0]    digit_reg, digit_next;
    logic [BASE_W-1:0]     pair_base_reg, pair_base_next;
    logic [15:0]           pair_counter_reg, pair_counter_next;
    logic [15:0]           second_counter_reg, second_counter_next;
    logic [7:0]            blink_counter_reg, blink_counter_next;
    logic                  blink_flag_reg, blink_flag_next;
    logic [CODE_DEPTH-1:0] written_reg;

    stage_t stage_reg, stage_next;
    logic   stage_valid_reg;

    logic [SHIFT_BITS-1:0] word_hi_reg, word_hi_next;
    logic [SHIFT_BITS-1:0] word_lo_reg, word_lo_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  active_reg, active_next;
    logic                  clk_pin_reg, clk_pin_next;
    logic                  dh_reg, dh_next;
    logic                  dl_reg, dl_next;
    logic                  le_reg, le_next;
    logic                  oe_reg, oe_next;
    logic [DIGITS-1:0]     anode_reg, anode_next;
    logic                  led_reg, led_next;

    result_t out_reg;
    logic    out_valid_reg;

    mode_t              item_mode;
    logic               accept;
    logic               out_free;
    logic               stage_fire;
    logic [COUNT_W-1:0] sensors_eff;
    logic               has_partner;
    logic               pair_wrap;
    logic               second_wrap;
    logic [7:0]         blink_inc;
    logic [ADDR_W-1:0]  addr_hi, addr_lo, addr_wr;
    logic               wr_en;
    logic               rd_en;
    logic [CODE_W-1:0]  rd_hi, rd_lo;

    assign item_mode  = mode_t'(item.mode);
    assign out_free   = !out_valid_reg || result.ready;
    assign stage_fire = stage_valid_reg && out_free;
    assign item.ready = !stage_valid_reg || out_free;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_count_reg   <= 4'd1;
            pair_hold_top_reg  <= 16'd1000;
            second_top_reg     <= 16'd100;
            blink_period_reg   <= 8'd100;
            blink_duration_reg <= 8'd50;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_SENSOR_COUNT:   sensor_count_reg   <= cfg.data[3:0];
                CFG_PAIR_HOLD_TOP:  pair_hold_top_reg  <= cfg.data;
                CFG_SECOND_TOP:     second_top_reg     <= cfg.data;
                CFG_BLINK_PERIOD:   blink_period_reg   <= cfg.data[7:0];
                CFG_BLINK_DURATION: blink_duration_reg <= cfg.data[7:0];
                default:            ;
            endcase
        end
    end

    // Front stage: address generation, counters and memory access.
    always_comb
    begin
        sensors_eff = (int'(sensor_count_reg) > MAX_SENSORS) ? COUNT_W'(MAX_SENSORS)
                                                            : COUNT_W'(sensor_count_reg);
        has_partner = (int'(pair_base_reg) + 2) <= int'(sensors_eff);

        digit_next = ((int'(digit_reg) + 1) >= DIGITS) ? '0 : digit_reg + DIGIT_W'(1);
        addr_hi    = ADDR_W'(int'(pair_base_reg) * DIGITS + int'(digit_next));
        addr_lo    = ADDR_W'((int'(pair_base_reg) + 1) * DIGITS + int'(digit_next));
        addr_wr    = ADDR_W'(int'(item.sensor_index) * DIGITS + int'(item.digit_index));

        pair_wrap = pair_counter_reg >= pair_hold_top_reg;
        if (pair_wrap)
        begin
            pair_counter_next = '0;
            pair_base_next    = ((int'(pair_base_reg) + 2) >= int'(sensors_eff)) ? '0
                                : BASE_W'(int'(pair_base_reg) + 2);
        end
        else
        begin
            pair_counter_next = pair_counter_reg + 16'd1;
            pair_base_next    = pair_base_reg;
        end

        second_wrap         = second_counter_reg >= second_top_reg;
        second_counter_next = second_wrap ? '0 : second_counter_reg + 16'd1;

        blink_inc = blink_counter_reg + 8'd1;
        if (blink_inc >= blink_period_reg)
        begin
            blink_counter_next = '0;
            blink_flag_next    = blink_flag_reg;
        end
        else
        begin
            blink_counter_next = blink_inc;
            blink_flag_next    = blink_inc < blink_duration_reg;
        end

        wr_en = accept && (item_mode == MODE_WRITE)
                && (int'(item.sensor_index) < MAX_SENSORS)
                && (int'(item.digit_index) < DIGITS);
        rd_en = accept && (item_mode == MODE_DIGIT);

        stage_next.mode         = item_mode;
        stage_next.digit        = (item_mode == MODE_DIGIT) ? digit_next : digit_reg;
        stage_next.pair_pulse   = (item_mode == MODE_DIGIT) && pair_wrap;
        stage_next.second_pulse = (item_mode == MODE_DIGIT) && second_wrap;
        stage_next.led          = blink_flag_next | item.button_indicator;
        stage_next.hi_ok        = written_reg[addr_hi[RAM_AW-1:0]];
        stage_next.lo_ok        = has_partner && written_reg[addr_lo[RAM_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg          <= '0;
            pair_base_reg      <= '0;
            pair_counter_reg   <= '0;
            second_counter_reg <= '0;
            blink_counter_reg  <= '0;
            blink_flag_reg     <= 1'b0;
            written_reg        <= '0;
            stage_valid_reg    <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                digit_reg          <= digit_next;
                pair_base_reg      <= pair_base_next;
                pair_counter_reg   <= pair_counter_next;
                second_counter_reg <= second_counter_next;
                blink_counter_reg  <= blink_counter_next;
                blink_flag_reg     <= blink_flag_next;
            end
            if (wr_en)
            begin
                written_reg[addr_wr[RAM_AW-1:0]] <= 1'b1;
            end
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (stage_fire)
            begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    mdsd_ram #(
        .WIDTH(CODE_W),
        .DEPTH(CODE_DEPTH)
    ) u_ram_hi (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(addr_wr[RAM_AW-1:0]),
        .wr_data(item.code_value),
        .rd_en  (rd_en),
        .rd_addr(addr_hi[RAM_AW-1:0]),
        .rd_data(rd_hi)
    );

    mdsd_ram #(
        .WIDTH(CODE_W),
        .DEPTH(CODE_DEPTH)
    ) u_ram_lo (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(addr_wr[RAM_AW-1:0]),
        .wr_data(item.code_value),
        .rd_en  (rd_en),
        .rd_addr(addr_lo[RAM_AW-1:0]),
        .rd_data(rd_lo)
    );

    // Back stage: shift words, serial sequence and pin levels.
    always_comb
    begin
        word_hi_next = word_hi_reg;
        word_lo_next = word_lo_reg;
        step_next    = step_reg;
        active_next  = active_reg;
        clk_pin_next = clk_pin_reg;
        dh_next      = dh_reg;
        dl_next      = dl_reg;
        le_next      = le_reg;
        oe_next      = oe_reg;
        anode_next   = anode_reg;
        led_next     = led_reg;

        case (stage_reg.mode)
            MODE_DIGIT:
            begin
                word_hi_next = stage_reg.hi_ok ? SHIFT_BITS'(rd_hi) : '0;
                word_lo_next = stage_reg.lo_ok ? SHIFT_BITS'(rd_lo) : '0;
                led_next     = stage_reg.led;
                oe_next      = 1'b1;
                anode_next   = '0;
                step_next    = '0;
                active_next  = 1'b1;
            end
            MODE_BIT:
            begin
                if (active_reg)
                begin
                    step_next = step_reg + STEP_W'(1);
                    if (step_reg < STEP_DATA_END)
                    begin
                        if (!step_reg[0])
                        begin
                            clk_pin_next = 1'b0;
                            dh_next      = word_hi_reg[SHIFT_BITS-1];
                            dl_next      = word_lo_reg[SHIFT_BITS-1];
                            word_hi_next = word_hi_reg << 1;
                            word_lo_next = word_lo_reg << 1;
                        end
                        else
                        begin
                            clk_pin_next = 1'b1;
                        end
                    end
                    else if (step_reg == STEP_DATA_END)
                    begin
                        clk_pin_next = 1'b0;
                        dh_next      = 1'b0;
                        dl_next      = 1'b0;
                    end
                    else if (step_reg == STEP_LATCH_ON)
                    begin
                        le_next = 1'b1;
                    end
                    else if (step_reg == STEP_LATCH_OFF)
                    begin
                        le_next = 1'b0;
                    end
                    else if (step_reg == STEP_ENABLE)
                    begin
                        oe_next = 1'b0;
                    end
                    else
                    begin
                        step_next   = '0;
                        anode_next  = DIGITS'(1) << stage_reg.digit;
                        active_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            active_reg    <= 1'b0;
            clk_pin_reg   <= 1'b0;
            dh_reg        <= 1'b0;
            dl_reg        <= 1'b0;
            le_reg        <= 1'b0;
            oe_reg        <= 1'b1;
            anode_reg     <= '0;
            led_reg       <= 1'b0;
            word_hi_reg   <= '0;
            word_lo_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (stage_fire)
            begin
                step_reg    <= step_next;
                active_reg  <= active_next;
                clk_pin_reg <= clk_pin_next;
                dh_reg      <= dh_next;
                dl_reg      <= dl_next;
                le_reg      <= le_next;
                oe_reg      <= oe_next;
                anode_reg   <= anode_next;
                led_reg     <= led_next;
                word_hi_reg <= word_hi_next;
                word_lo_reg <= word_lo_next;
            end
            if (stage_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            out_reg.shift_clock    <= clk_pin_next;
            out_reg.data_high      <= dh_next;
            out_reg.data_low       <= dl_next;
            out_reg.latch_enable   <= le_next;
            out_reg.output_disable <= oe_next;
            out_reg.anode_select   <= anode_next;
            out_reg.indicator_led  <= led_next;
            out_reg.pair_pulse     <= stage_reg.pair_pulse;
            out_reg.second_pulse   <= stage_reg.second_pulse;
            out_reg.busy_res       <= active_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.shift_clock    = out_reg.shift_clock;
    assign result.data_high      = out_reg.data_high;
    assign result.data_low       = out_reg.data_low;
    assign result.latch_enable   = out_reg.latch_enable;
    assign result.output_disable = out_reg.output_disable;
    assign result.anode_select   = out_reg.anode_select;
    assign result.indicator_led  = out_reg.indicator_led;
    assign result.pair_pulse     = out_reg.pair_pulse;
    assign result.second_pulse   = out_reg.second_pulse;
    assign result.busy_res       = out_reg.busy_res;

endmodule

`default_nettype wire

/* rtl/mdsd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mdsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 40
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/mdsd_checker.sv */
// Port-level assertions for the display driver and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mdsd_checker import mdsd_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire logic [DIGITS-1:0] anode_select,
    input wire logic              latch_enable,
    input wire logic              busy_res
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(anode_select))
        else $error("Stalled result changed.");

    a_anode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $onehot0(anode_select))
        else $error("More than one anode driven.");

    a_blank_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && busy_res |-> anode_select == '0)
        else $error("Anode driven during a shift sequence.");

    a_latch_in_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && latch_enable |-> busy_res)
        else $error("Latch raised outside a shift sequence.");

endmodule

bind multiplexed_display_shift_driver mdsd_checker u_mdsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .result_valid(result.valid),
    .result_ready(result.ready),
    .anode_select(result.anode_select),
    .latch_enable(result.latch_enable),
    .busy_res    (result.busy_res)
);

`default_nettype wire

/* verif/multiplexed_display_shift_driver_tb.sv */
// Testbench of the display driver: a directed table, then random requests checked by a predictor.
`timescale 1ns / 1ps

module multiplexed_display_shift_driver_tb;
    import mdsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_REQUESTS = 75;
    localparam int PHASES         = 7;

    typedef struct packed {
        mode_t       mode;
        logic [2:0]  sensor;
        logic [2:0]  digit;
        logic [15:0] code;
        logic        button;
    } request_t;

    typedef struct {
        request_t req;
        int       reps;
        bit       typed;
        result_t  golden;
    } stim_row_t;

    localparam result_t PINS_AT_RESET = '{shift_clock: 1'b0, data_high: 1'b0,
        data_low: 1'b0, latch_enable: 1'b0, output_disable: 1'b1, anode_select: '0,
        indicator_led: 1'b0, pair_pulse: 1'b0, second_pulse: 1'b0, busy_res: 1'b0};
    localparam result_t PINS_FIRST_DIGIT = '{shift_clock: 1'b0, data_high: 1'b0,
        data_low: 1'b0, latch_enable: 1'b0, output_disable: 1'b1, anode_select: '0,
        indicator_led: 1'b1, pair_pulse: 1'b0, second_pulse: 1'b0, busy_res: 1'b1};

    logic clk = 1'b0;
    logic rst_n;

    mdsd_item_if   item_bus ();
    mdsd_result_if result_bus ();
    mdsd_cfg_if    cfg_bus ();

    multiplexed_display_shift_driver dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always #1 clk = ~clk;

    // Predictor state of the display driver.
    logic [CODE_W-1:0]     code_mem [CODE_DEPTH];
    logic [SHIFT_BITS-1:0] word_hi;
    logic [SHIFT_BITS-1:0] word_lo;
    int unsigned digit_pos;
    int unsigned pair_base;
    int unsigned pair_cnt;
    int unsigned sec_cnt;
    int unsigned blink_cnt;
    int unsigned seq_step;
    bit          blink_on;
    bit          shifting;
    result_t     pin_state;

    int unsigned cfg_sensors;
    int unsigned cfg_pair_top;
    int unsigned cfg_sec_top;
    int unsigned cfg_blink_period;
    int unsigned cfg_blink_dur;

    result_t     pending_pins [$];
    stim_row_t   directed_rows [$];
    int unsigned errors;
    int unsigned effective_requests;
    int unsigned frames_done;
    int unsigned pair_wraps;
    int unsigned second_wraps;
    int unsigned settings_used;

    bit   source_gaps;
    bit   sink_gaps;
    logic sink_hold;
    event holdoff_go;

    task automatic step_display(input request_t r, output result_t res);
        int unsigned n;
        bit          pair_wrap;
        bit          sec_wrap;
        pair_wrap = 1'b0;
        sec_wrap  = 1'b0;
        case (r.mode)
            MODE_WRITE:
            begin
                if (r.sensor < MAX_SENSORS && r.digit < DIGITS) begin
                    code_mem[r.sensor * DIGITS + r.digit] = r.code;
                    effective_requests++;
                end
            end
            MODE_DIGIT:
            begin
                effective_requests++;
                n = (cfg_sensors > MAX_SENSORS) ? MAX_SENSORS : cfg_sensors;
                digit_pos = (digit_pos + 1 >= DIGITS) ? 0 : digit_pos + 1;
                word_hi = code_mem[pair_base * DIGITS + digit_pos];
                if (pair_base + 2 <= n)
                    word_lo = code_mem[(pair_base + 1) * DIGITS + digit_pos];
                else
                    word_lo = '0;
                if (pair_cnt >= cfg_pair_top) begin
                    pair_cnt  = 0;
                    pair_wrap = 1'b1;
                    pair_base += 2;
                    if (pair_base >= n)
                        pair_base = 0;
                end else begin
                    pair_cnt = (pair_cnt + 1) & 16'hFFFF;
                end
                if (sec_cnt >= cfg_sec_top) begin
                    sec_cnt  = 0;
                    sec_wrap = 1'b1;
                end else begin
                    sec_cnt = (sec_cnt + 1) & 16'hFFFF;
                end
                blink_cnt = (blink_cnt + 1) & 8'hFF;
                if (blink_cnt >= cfg_blink_period)
                    blink_cnt = 0;
                else
                    blink_on = (blink_cnt < cfg_blink_dur);
                pin_state.indicator_led  = blink_on | r.button;
                pin_state.output_disable = 1'b1;
                pin_state.anode_select   = '0;
                seq_step = 0;
                shifting = 1'b1;
                pair_wraps   += pair_wrap;
                second_wraps += sec_wrap;
            end
            MODE_BIT:
            begin
                if (shifting) begin
                    effective_requests++;
                    if (seq_step < DATA_STEPS) begin
                        if (seq_step % 2 == 0) begin
                            pin_state.shift_clock = 1'b0;
                            pin_state.data_high   = word_hi[SHIFT_BITS-1];
                            pin_state.data_low    = word_lo[SHIFT_BITS-1];
                            word_hi = word_hi << 1;
                            word_lo = word_lo << 1;
                        end else begin
                            pin_state.shift_clock = 1'b1;
                        end
                        seq_step++;
                    end else if (seq_step == DATA_STEPS) begin
                        pin_state.shift_clock = 1'b0;
                        pin_state.data_high   = 1'b0;
                        pin_state.data_low    = 1'b0;
                        seq_step++;
                    end else if (seq_step == DATA_STEPS + 1) begin
                        pin_state.latch_enable = 1'b1;
                        seq_step++;
                    end else if (seq_step == DATA_STEPS + 2) begin
                        pin_state.latch_enable = 1'b0;
                        seq_step++;
                    end else if (seq_step == DATA_STEPS + 3) begin
                        pin_state.output_disable = 1'b0;
                        seq_step++;
                    end else begin
                        seq_step = 0;
                        pin_state.anode_select = DIGITS'(1 << digit_pos);
                        shifting = 1'b0;
                        frames_done++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res              = pin_state;
        res.pair_pulse   = pair_wrap;
        res.second_pulse = sec_wrap;
        res.busy_res     = shifting;
    endtask

    function automatic request_t random_request(mode_t m);
        request_t r;
        r.mode   = m;
        r.sensor = 3'($urandom_range(0, 7));
        r.digit  = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
            0:       r.code = '0;
            1:       r.code = '1;
            default: r.code = 16'($urandom);
        endcase
        r.button = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic add_row(mode_t m, logic [2:0] s, logic [2:0] d, logic [15:0] c, logic b,
                           int reps, bit typed, result_t golden);
        stim_row_t row;
        row.req    = '{mode: m, sensor: s, digit: d, code: c, button: b};
        row.reps   = reps;
        row.typed  = typed;
        row.golden = golden;
        directed_rows.push_back(row);
    endtask

    task automatic send_request(request_t r, bit typed, result_t golden);
        result_t predicted;
        while (source_gaps && $urandom_range(0, 99) < 8) begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid            <= 1'b1;
        item_bus.mode             <= r.mode;
        item_bus.sensor_index     <= r.sensor;
        item_bus.digit_index      <= r.digit;
        item_bus.code_value       <= r.code;
        item_bus.button_indicator <= r.button;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        step_display(r, predicted);
        pending_pins.push_back(typed ? golden : predicted);
    endtask

    task automatic write_register(cfg_index_t idx, logic [15:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            CFG_SENSOR_COUNT:   cfg_sensors      = value & 16'h000F;
            CFG_PAIR_HOLD_TOP:  cfg_pair_top     = value;
            CFG_SECOND_TOP:     cfg_sec_top      = value;
            CFG_BLINK_PERIOD:   cfg_blink_period = value & 16'h00FF;
            CFG_BLINK_DURATION: cfg_blink_dur    = value & 16'h00FF;
            default:            ;
        endcase
    endtask

    task automatic drain_requests();
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_pins.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_pin(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            errors++;
        end
    endfunction

    initial begin : result_sink
        result_t got;
        result_t want;
        result_bus.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready) begin
                got = {result_bus.shift_clock, result_bus.data_high, result_bus.data_low,
                       result_bus.latch_enable, result_bus.output_disable,
                       result_bus.anode_select, result_bus.indicator_led,
                       result_bus.pair_pulse, result_bus.second_pulse, result_bus.busy_res};
                if (pending_pins.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    errors++;
                end else begin
                    want = pending_pins.pop_front();
                    check_pin("shift_clock", want.shift_clock, got.shift_clock);
                    check_pin("data_high", want.data_high, got.data_high);
                    check_pin("data_low", want.data_low, got.data_low);
                    check_pin("latch_enable", want.latch_enable, got.latch_enable);
                    check_pin("output_disable", want.output_disable, got.output_disable);
                    check_pin("anode_select", want.anode_select, got.anode_select);
                    check_pin("indicator_led", want.indicator_led, got.indicator_led);
                    check_pin("pair_pulse", want.pair_pulse, got.pair_pulse);
                    check_pin("second_pulse", want.second_pulse, got.second_pulse);
                    check_pin("busy_res", want.busy_res, got.busy_res);
                end
            end
            result_bus.ready <= !sink_hold && !(sink_gaps && $urandom_range(0, 99) < 8);
        end
    end

    initial begin : sink_holdoff
        sink_hold = 1'b0;
        @(holdoff_go);
        sink_hold <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
                    || (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[multiplexed_display_shift_driver] ERROR");
        $finish;
    end

    initial begin : stimulus
        request_t    r;
        logic [15:0] setting [5];
        int unsigned start;
        int unsigned burst;
        int unsigned sel;
        bit          paused;

        rst_n                     = 1'b0;
        item_bus.valid            = 1'b0;
        item_bus.mode             = MODE_NONE;
        item_bus.sensor_index     = '0;
        item_bus.digit_index      = '0;
        item_bus.code_value       = '0;
        item_bus.button_indicator = 1'b0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.index             = CFG_SENSOR_COUNT;
        cfg_bus.data              = '0;
        source_gaps = 1'b1;
        sink_gaps   = 1'b1;

        foreach (code_mem[i])
            code_mem[i] = '0;
        word_hi = '0;
        word_lo = '0;
        digit_pos = 0;
        pair_base = 0;
        pair_cnt  = 0;
        sec_cnt   = 0;
        blink_cnt = 0;
        seq_step  = 0;
        blink_on  = 1'b0;
        shifting  = 1'b0;
        pin_state = PINS_AT_RESET;
        cfg_sensors      = 1;
        cfg_pair_top     = 1000;
        cfg_sec_top      = 100;
        cfg_blink_period = 100;
        cfg_blink_dur    = 50;
        errors = 0;
        effective_requests = 0;
        frames_done  = 0;
        pair_wraps   = 0;
        second_wraps = 0;
        settings_used = 1;

        // Directed part, run with the register values left by reset (single sensor, no partner).
        add_row(MODE_NONE, 3'd0, 3'd0, 16'h0000, 1'b0, 1, 1'b1, PINS_AT_RESET);
        add_row(MODE_BIT, 3'd0, 3'd0, 16'h0000, 1'b0, 1, 1'b1, PINS_AT_RESET);
        add_row(MODE_WRITE, 3'd0, 3'd1, 16'hFFFF, 1'b0, 1, 1'b1, PINS_AT_RESET);
        add_row(MODE_WRITE, 3'd1, 3'd1, 16'hA5A5, 1'b1, 1, 1'b0, PINS_AT_RESET);
        add_row(MODE_WRITE, 3'd0, 3'd2, 16'h0001, 1'b0, 1, 1'b0, PINS_AT_RESET);
        add_row(MODE_WRITE, 3'd0, 3'd7, 16'h1234, 1'b0, 1, 1'b0, PINS_AT_RESET);
        add_row(MODE_WRITE, 3'd7, 3'd4, 16'h8000, 1'b0, 1, 1'b0, PINS_AT_RESET);
        add_row(MODE_WRITE, 3'd7, 3'd5, 16'hFFFF, 1'b1, 1, 1'b0, PINS_AT_RESET);
        add_row(MODE_DIGIT, 3'd0, 3'd0, 16'h0000, 1'b0, 1, 1'b1, PINS_FIRST_DIGIT);
        add_row(MODE_BIT, 3'd0, 3'd0, 16'h0000, 1'b0, 5, 1'b0, PINS_AT_RESET);
        add_row(MODE_DIGIT, 3'd7, 3'd7, 16'hFFFF, 1'b1, 1, 1'b0, PINS_AT_RESET);
        add_row(MODE_NONE, 3'd7, 3'd7, 16'hFFFF, 1'b1, 1, 1'b0, PINS_AT_RESET);
        add_row(MODE_BIT, 3'd5, 3'd2, 16'h5A5A, 1'b1, 37, 1'b0, PINS_AT_RESET);
        add_row(MODE_BIT, 3'd0, 3'd0, 16'h0000, 1'b0, 1, 1'b0, PINS_AT_RESET);
        add_row(MODE_WRITE, 3'd0, 3'd3, 16'h0000, 1'b0, 1, 1'b0, PINS_AT_RESET);
        add_row(MODE_DIGIT, 3'd0, 3'd0, 16'h0000, 1'b0, 1, 1'b0, PINS_AT_RESET);
        add_row(MODE_BIT, 3'd3, 3'd6, 16'hFFFF, 1'b0, 40, 1'b0, PINS_AT_RESET);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            repeat (directed_rows[i].reps)
                send_request(directed_rows[i].req, directed_rows[i].typed,
                             directed_rows[i].golden);

        for (int p = 0; p < PHASES; p++) begin
            drain_requests();
            case (p)
                0: setting = '{16'd2, 16'd3, 16'd4, 16'd10, 16'd5};
                1: setting = '{16'd8, 16'd0, 16'd0, 16'd1, 16'd0};
                2: setting = '{16'd15, 16'd65535, 16'd65535, 16'd255, 16'd255};
                3: setting = '{16'd3, 16'd1, 16'd2, 16'd0, 16'd1};
                4: setting = '{16'd5, 16'd6, 16'd0, 16'd7, 16'd3};
                5: setting = '{16'd1, 16'd2, 16'd1, 16'd4, 16'd4};
                default:
                    setting = '{16'($urandom_range(1, 15)), 16'($urandom_range(0, 5)),
                                16'($urandom_range(0, 5)), 16'($urandom_range(0, 12)),
                                16'($urandom_range(0, 12))};
            endcase
            write_register(CFG_SENSOR_COUNT, setting[0]);
            write_register(CFG_PAIR_HOLD_TOP, setting[1]);
            write_register(CFG_SECOND_TOP, setting[2]);
            write_register(CFG_BLINK_PERIOD, setting[3]);
            write_register(CFG_BLINK_DURATION, setting[4]);
            cfg_bus.valid <= 1'b0;
            settings_used++;

            // One phase runs with no gaps on either side.
            source_gaps = (p != 3);
            sink_gaps   = (p != 3);
            if (p == 2)
                -> holdoff_go;
            paused = 1'b0;
            start  = effective_requests;
            while (effective_requests - start < PHASE_REQUESTS) begin
                if (p == 1 && !paused && effective_requests - start >= PHASE_REQUESTS / 2) begin
                    paused = 1'b1;
                    drain_requests();
                end
                sel = $urandom_range(0, 99);
                if (sel < 40) begin
                    send_request(random_request(MODE_WRITE), 1'b0, PINS_AT_RESET);
                end else if (sel < 45) begin
                    send_request(random_request(MODE_NONE), 1'b0, PINS_AT_RESET);
                end else begin
                    send_request(random_request(MODE_DIGIT), 1'b0, PINS_AT_RESET);
                    burst = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 40)
                                                        : 36 + $urandom_range(0, 2);
                    repeat (burst)
                        send_request(random_request(MODE_BIT), 1'b0, PINS_AT_RESET);
                end
            end
        end

        drain_requests();
        repeat (8) @(posedge clk);
        $display("Covered %0d effective requests under %0d register settings.",
                 effective_requests, settings_used);
        $display("Saw %0d completed refreshes, %0d pair rotations and %0d second pulses.",
                 frames_done, pair_wraps, second_wraps);
        if (errors == 0)
            $display("[multiplexed_display_shift_driver] OK");
        else
            $display("[multiplexed_display_shift_driver] ERROR");
        $finish;
    end

endmodule
